@@ sv/aes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, substitution tables and field arithmetic for the AES core.
// ----------------------------------------------------------------------------
package aes_pkg;

   // Key size codes of the key_size register.
   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_KEY_SIZE = 3'd0;
   localparam logic [2:0] REG_KEY_W0   = 3'd1;
   localparam logic [2:0] REG_KEY_W1   = 3'd2;
   localparam logic [2:0] REG_KEY_W2   = 3'd3;
   localparam logic [2:0] REG_KEY_W3   = 3'd4;

   // Request direction codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Round-key store geometry: one row of four words per round.
   localparam int KEY_ROWS = 15;

   typedef struct packed {
      logic        req_type;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
   } aes_req_type;

   typedef struct packed {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
   } aes_rsp_type;

   // Status of the key schedule unit toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } aes_ks_status_type;

   // Forward S-box, entry 0 in the most significant byte.
   localparam logic [2047:0] SBOX_FWD = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   // Inverse S-box, entry 0 in the most significant byte.
   localparam logic [2047:0] SBOX_INV = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
      return SBOX_FWD[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] sbox_inv(input logic [7:0] x);
      return SBOX_INV[{~x, 3'b000} +: 8];
   endfunction

   // Multiplication by two in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1.
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
   endfunction

endpackage : aes_pkg
`default_nettype wire

@@ sv/aes_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round
// Shared round unit: the initial key addition or one encryption or decryption round per pass.
// ----------------------------------------------------------------------------
module aes_round
   import aes_pkg::*;
(
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] round_key,
   input  wire logic         decrypt,
   input  wire logic         first,
   input  wire logic         no_mix,
   output logic      [127:0] state_out
);

   logic [127:0] sub_fwd;
   logic [127:0] shf_fwd;
   logic [127:0] mix_fwd;
   logic [127:0] shf_inv;
   logic [127:0] sub_inv;
   logic [127:0] key_inv;
   logic [127:0] mix_inv;

   // Byte n of the state sits at bits 127-8n; column c holds bytes 4c to 4c+3.
   always_comb begin
      for (int n = 0; n < 16; n++) begin
         sub_fwd[127 - 8*n -: 8] = sbox_fwd(state_in[127 - 8*n -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shf_fwd[127 - 8*(4*c + r) -: 8] = sub_fwd[127 - 8*(4*((c + r) % 4) + r) -: 8];
            shf_inv[127 - 8*(4*c + r) -: 8] = state_in[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8];
         end
      end
      for (int n = 0; n < 16; n++) begin
         sub_inv[127 - 8*n -: 8] = sbox_inv(shf_inv[127 - 8*n -: 8]);
      end
      key_inv = sub_inv ^ round_key;
   end

   // Forward and inverse column mixing.
   always_comb begin
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] b0, b1, b2, b3;
      logic [7:0] d0, d1, d2, d3;
      logic [7:0] q0, q1, q2, q3;
      for (int c = 0; c < 4; c++) begin
         a0 = shf_fwd[127 - 32*c -: 8];
         a1 = shf_fwd[119 - 32*c -: 8];
         a2 = shf_fwd[111 - 32*c -: 8];
         a3 = shf_fwd[103 - 32*c -: 8];
         mix_fwd[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mix_fwd[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mix_fwd[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mix_fwd[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);

         b0 = key_inv[127 - 32*c -: 8];
         b1 = key_inv[119 - 32*c -: 8];
         b2 = key_inv[111 - 32*c -: 8];
         b3 = key_inv[103 - 32*c -: 8];
         // Doubles, quadruples and octuples give 9, 11, 13 and 14 by sums.
         d0 = xtime(b0); d1 = xtime(b1); d2 = xtime(b2); d3 = xtime(b3);
         q0 = xtime(d0); q1 = xtime(d1); q2 = xtime(d2); q3 = xtime(d3);
         mix_inv[127 - 32*c -: 8] = (xtime(q0) ^ q0 ^ d0) ^ (xtime(q1) ^ d1 ^ b1)
                                  ^ (xtime(q2) ^ q2 ^ b2) ^ (xtime(q3) ^ b3);
         mix_inv[119 - 32*c -: 8] = (xtime(q0) ^ b0) ^ (xtime(q1) ^ q1 ^ d1)
                                  ^ (xtime(q2) ^ d2 ^ b2) ^ (xtime(q3) ^ q3 ^ b3);
         mix_inv[111 - 32*c -: 8] = (xtime(q0) ^ q0 ^ b0) ^ (xtime(q1) ^ b1)
                                  ^ (xtime(q2) ^ q2 ^ d2) ^ (xtime(q3) ^ d3 ^ b3);
         mix_inv[103 - 32*c -: 8] = (xtime(q0) ^ d0 ^ b0) ^ (xtime(q1) ^ q1 ^ b1)
                                  ^ (xtime(q2) ^ b2) ^ (xtime(q3) ^ q3 ^ d3);
      end
   end

   // Select the step: the initial key addition, a full round, or the last round without column mixing.
   always_comb begin
      if (first) begin
         state_out = state_in ^ round_key;
      end else if (decrypt) begin
         state_out = no_mix ? key_inv : mix_inv;
      end else begin
         state_out = (no_mix ? shf_fwd : mix_fwd) ^ round_key;
      end
   end

endmodule : aes_round
`default_nettype wire

@@ sv/aes_key_sched.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_key_sched
// Key expansion, one schedule word per cycle, into the round-key store.
// ----------------------------------------------------------------------------
module aes_key_sched
   import aes_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        key_size,
   input  wire logic [63:0]       key_words [4],
   input  wire logic [3:0]        rd_row,
   output logic      [127:0]      rd_data,
   output aes_ks_status_type      status
);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [2:0]        mc_ff, mc_in;
   logic [7:0]        rc_ff, rc_in;
   logic [31:0]       win_ff [8];
   logic [127:0]      rd_ff;
   logic [127:0]      mem [KEY_ROWS];

   logic [3:0]        nk;
   logic [5:0]        last_idx;
   logic [63:0]       kw;
   logic [31:0]       tmp;
   logic [31:0]       word;

   // Key length in words and the index of the last schedule word.
   always_comb begin
      unique case (key_size)
         KEY_SIZE_128: begin nk = 4'd4; last_idx = 6'd43; end
         KEY_SIZE_192: begin nk = 4'd6; last_idx = 6'd51; end
         default:      begin nk = 4'd8; last_idx = 6'd59; end
      endcase
   end

   // Next schedule word: copied from the key, or derived from earlier words.
   always_comb begin
      kw   = key_words[cnt_ff[2:1]];
      tmp  = win_ff[0];
      if (mc_ff == 3'd0) begin
         tmp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rc_ff, 24'h000000};
      end else if (nk == 4'd8 && mc_ff == 3'd4) begin
         tmp = sub_word(win_ff[0]);
      end
      if (cnt_ff < {2'b00, nk}) begin
         word = cnt_ff[0] ? kw[31:0] : kw[63:32];
      end else begin
         word = win_ff[nk[2:0] - 3'd1] ^ tmp;
      end
   end

   // Sequencing of the expansion pass.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mc_in     = mc_ff;
      rc_in     = rc_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 6'd0;
         mc_in     = 3'd0;
         rc_in     = 8'h01;
      end else if (active_ff) begin
         cnt_in = cnt_ff + 6'd1;
         mc_in  = ({1'b0, mc_ff} == nk - 4'd1) ? 3'd0 : mc_ff + 3'd1;
         if (cnt_ff >= {2'b00, nk} && mc_ff == 3'd0) begin
            rc_in = xtime(rc_ff);
         end
         if (cnt_ff == last_idx) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      mc_ff  <= mc_in;
      rc_ff  <= rc_in;
   end

   // Window of the last eight schedule words.
   always_ff @(posedge clock) begin
      if (active_ff) begin
         win_ff[0] <= word;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // Round-key store: one word written per cycle, one row read per cycle.
   always_ff @(posedge clock) begin
      if (active_ff) begin
         mem[cnt_ff[5:2]][{~cnt_ff[1:0], 5'b00000} +: 32] <= word;
      end
      rd_ff <= mem[rd_row];
   end

   assign rd_data     = rd_ff;
   assign status.busy = active_ff;
   assign status.done = done_ff;

endmodule : aes_key_sched
`default_nettype wire

@@ sv/aes_block_cipher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 block cipher with an iterative round unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// loads the first round key from the store and runs the block through the
// shared round unit: the initial key addition, then Nr rounds (Nr = 10, 12
// or 14). The result appears on rsp_data, where it stays until the next
// result, with rsp_valid high in the same cycle; the receiver cannot stall
// it and must take it then. busy is low in that output cycle, so the next
// request may be given there. The first request after reset or after any
// key register write first runs the key expansion, one schedule word per
// cycle, while busy stays high. The round-key store delivers one row per
// cycle, which sets the one-round-per-cycle pace.
// ----------------------------------------------------------------------------
module aes_block_cipher
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire aes_req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output aes_rsp_type      rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXPAND = 2'd1;
   localparam logic [1:0] ST_LOAD   = 2'd2;
   localparam logic [1:0] ST_RUN    = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              ready_ff, ready_in;
   logic [1:0]        key_size_ff;
   logic [63:0]       key_words_ff [4];
   logic              mode_ff, mode_in;
   logic [127:0]      data_ff, data_in;
   logic [3:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [127:0]      rsp_ff;

   logic              csr_wr;
   logic [3:0]        nr;
   logic [3:0]        rd_step;
   logic [3:0]        rd_row;
   logic              ks_start;
   logic [127:0]      round_key;
   logic [127:0]      round_out;
   aes_ks_status_type ks_status;

   // Configuration registers.
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= 2'd0;
         for (int k = 0; k < 4; k++) begin
            key_words_ff[k] <= 64'd0;
         end
      end else if (csr_wr) begin
         unique case (csr_paddr[5:3])
            REG_KEY_SIZE: key_size_ff     <= csr_pwdata[1:0];
            REG_KEY_W0:   key_words_ff[0] <= csr_pwdata;
            REG_KEY_W1:   key_words_ff[1] <= csr_pwdata;
            REG_KEY_W2:   key_words_ff[2] <= csr_pwdata;
            REG_KEY_W3:   key_words_ff[3] <= csr_pwdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_KEY_SIZE: csr_prdata = {62'd0, key_size_ff};
         REG_KEY_W0:   csr_prdata = key_words_ff[0];
         REG_KEY_W1:   csr_prdata = key_words_ff[1];
         REG_KEY_W2:   csr_prdata = key_words_ff[2];
         REG_KEY_W3:   csr_prdata = key_words_ff[3];
         default:      csr_prdata = 64'd0;
      endcase
   end

   // Round count from the key size.
   always_comb begin
      unique case (key_size_ff)
         KEY_SIZE_128: nr = 4'd10;
         KEY_SIZE_192: nr = 4'd12;
         default:      nr = 4'd14;
      endcase
   end

   // Round-key row for the step after the current one, held at the last step.
   always_comb begin
      if (state_ff == ST_RUN && step_ff != nr) begin
         rd_step = step_ff + 4'd1;
      end else if (state_ff == ST_RUN) begin
         rd_step = step_ff;
      end else begin
         rd_step = 4'd0;
      end
      rd_row = (mode_ff == OP_DECRYPT) ? nr - rd_step : rd_step;
   end

   // Request sequencer.
   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      mode_in      = mode_ff;
      data_in      = data_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      ks_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_data.req_type;
               data_in = {req_data.block_hi, req_data.block_lo};
               if (ready_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  ks_start = 1'b1;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            if (ks_status.done) begin
               ready_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            step_in  = 4'd0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            data_in = round_out;
            step_in = step_ff + 4'd1;
            if (step_ff == nr) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // A key register write invalidates the expanded schedule.
      if (csr_wr && csr_paddr[5:3] <= REG_KEY_W3) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      data_ff <= data_in;
      step_ff <= step_in;
      if (rsp_valid_in) begin
         rsp_ff <= round_out;
      end
   end

   aes_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .start     (ks_start),
      .key_size  (key_size_ff),
      .key_words (key_words_ff),
      .rd_row    (rd_row),
      .rd_data   (round_key),
      .status    (ks_status)
   );

   aes_round u_round (
      .state_in  (data_ff),
      .round_key (round_key),
      .decrypt   (mode_ff),
      .first     (step_ff == 4'd0),
      .no_mix    (step_ff == nr),
      .state_out (round_out)
   );

   assign busy            = (state_ff != ST_IDLE) | ks_status.busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data.out_hi = rsp_ff[127:64];
   assign rsp_data.out_lo = rsp_ff[63:0];

endmodule : aes_block_cipher
`default_nettype wire

@@ test/aes_block_cipher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_test
// Self-checking bench for the AES block cipher with 128/192/256-bit keys.
// A queue of requests feeds a clocked driver, and a clocked monitor compares
// every result with a bench-side cipher model. Phases step through each key
// size, including the unused size code, with extreme and random keys. Idle
// bursts fall between requests, except in the last phase.
// ----------------------------------------------------------------------------
module aes_block_cipher_test;
   import aes_pkg::*;

   localparam logic [1:0] KEY_SIZE_256    = 2'd2;
   localparam logic [1:0] KEY_SIZE_UNUSED = 2'd3;
   localparam logic [2:0] REG_BEYOND      = 3'd5;
   localparam int         QUIET_LIMIT     = 2000;
   localparam int         PHASES          = 9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   aes_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   aes_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   aes_block_cipher dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the cipher state.
   logic [7:0]  fwd_tab [256];
   logic [7:0]  inv_tab [256];
   logic [1:0]  model_key_size;
   logic [63:0] model_key [4];
   logic [31:0] sched [60];
   logic        sched_valid;
   logic [7:0]  st [16];

   aes_req_type pending_requests [$];
   aes_rsp_type expected_blocks [$];
   bit          calm;
   int          gap;
   int          failures;
   int          quiet;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // Build both substitution tables from the field inverse and the affine map.
   task automatic build_tables();
      logic [7:0] p;
      logic [7:0] b;
      for (int x = 0; x < 256; x++) begin
         p = 8'h01;
         if (x == 0) p = 8'h00;
         else repeat (254) p = gf_mul(p, x[7:0]);
         b = p ^ rotl8(p, 1) ^ rotl8(p, 2) ^ rotl8(p, 3) ^ rotl8(p, 4) ^ 8'h63;
         fwd_tab[x] = b;
         inv_tab[b] = x[7:0];
      end
   endtask

   function automatic int key_words_of(input logic [1:0] ks);
      return ks == KEY_SIZE_128 ? 4 : (ks == KEY_SIZE_192 ? 6 : 8);
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
   endfunction

   task automatic expand_keys();
      int nk;
      int total;
      logic [7:0] rc;
      logic [31:0] t;
      nk = key_words_of(model_key_size);
      total = 4 * (nk + 7);
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? model_key[i >> 1][31:0] : model_key[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_mul(rc, 8'h02);
         end else if (nk > 6 && i % nk == 4) begin
            t = subst_word(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
      sched_valid = 1'b1;
   endtask

   task automatic add_round_key(input int rnd);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            st[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
   endtask

   task automatic sub_shift(input bit inverse);
      logic [7:0] t [16];
      int src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = inverse ? ((c + 4 - r) & 3) : ((c + r) & 3);
            t[4 * c + r] = inverse ? inv_tab[st[4 * src + r]] : fwd_tab[st[4 * src + r]];
         end
      st = t;
   endtask

   // Column mix with the coefficient row m, first coefficient in m[0].
   task automatic mix_cols(input logic [0:3][7:0] m);
      logic [7:0] a [4];
      logic [7:0] acc;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) a[j] = st[4 * c + j];
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++) acc ^= gf_mul(a[j], m[(4 + j - r) & 3]);
            st[4 * c + r] = acc;
         end
      end
   endtask

   // Expected cipher output for one accepted request.
   task automatic predict_block(input aes_req_type rq, output aes_rsp_type rs);
      int nr;
      if (!sched_valid) expand_keys();
      nr = key_words_of(model_key_size) + 6;
      for (int i = 0; i < 8; i++) begin
         st[i] = rq.block_hi[63 - 8 * i -: 8];
         st[8 + i] = rq.block_lo[63 - 8 * i -: 8];
      end
      if (rq.req_type == OP_ENCRYPT) begin
         add_round_key(0);
         for (int rnd = 1; rnd <= nr; rnd++) begin
            sub_shift(1'b0);
            if (rnd != nr) mix_cols({8'd2, 8'd3, 8'd1, 8'd1});
            add_round_key(rnd);
         end
      end else begin
         add_round_key(nr);
         for (int rnd = nr - 1; rnd >= 0; rnd--) begin
            sub_shift(1'b1);
            add_round_key(rnd);
            if (rnd != 0) mix_cols({8'd14, 8'd11, 8'd13, 8'd9});
         end
      end
      for (int i = 0; i < 8; i++) begin
         rs.out_hi[63 - 8 * i -: 8] = st[i];
         rs.out_lo[63 - 8 * i -: 8] = st[8 + i];
      end
   endtask

   // Register write through the configuration port; the model follows it.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_KEY_SIZE) begin
         model_key_size = value[1:0];
         sched_valid = 1'b0;
      end else if (idx <= REG_KEY_W3) begin
         model_key[idx - 1] = value;
         sched_valid = 1'b0;
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic aes_req_type make_request(input logic op, input logic [63:0] hi,
                                                input logic [63:0] lo);
      aes_req_type rq;
      rq.req_type = op;
      rq.block_hi = hi;
      rq.block_lo = lo;
      return rq;
   endfunction

   // Wait until every queued request is taken and every result has come back.
   task automatic drain();
      while (pending_requests.size() != 0 || start || expected_blocks.size() != 0)
         @(posedge clock);
   endtask

   // Driver: takes requests from the pending queue, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            aes_rsp_type rs;
            predict_block(req_data, rs);
            expected_blocks.push_back(rs);
            if (!calm && $urandom_range(3) == 0) gap = $urandom_range(4, 1);
         end
         if (!start || !busy) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_data <= pending_requests.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            failures++;
         end else begin
            aes_rsp_type exp_rs;
            exp_rs = expected_blocks.pop_front();
            if (rsp_data.out_hi !== exp_rs.out_hi) begin
               $display("%0t: out_hi mismatch, expected %h, actual %h",
                        $time, exp_rs.out_hi, rsp_data.out_hi);
               failures++;
            end
            if (rsp_data.out_lo !== exp_rs.out_lo) begin
               $display("%0t: out_lo mismatch, expected %h, actual %h",
                        $time, exp_rs.out_lo, rsp_data.out_lo);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_psel && csr_penable))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [1:0] ks;
      failures = 0;
      gap = 0;
      calm = 1'b0;
      quiet = 0;
      model_key_size = KEY_SIZE_128;
      for (int i = 0; i < 4; i++) model_key[i] = '0;
      sched_valid = 1'b0;
      build_tables();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset key (all zero, 128 bits): block extremes in both directions.
      pending_requests.push_back(make_request(OP_ENCRYPT, '0, '0));
      pending_requests.push_back(make_request(OP_ENCRYPT, '1, '1));
      pending_requests.push_back(make_request(OP_DECRYPT, '0, '0));
      pending_requests.push_back(make_request(OP_DECRYPT, '1, '1));
      pending_requests.push_back(make_request(OP_ENCRYPT, 64'h8000000000000000, 64'h1));
      drain();

      // Standard 128-bit example key and block, then decrypt of its cipher text.
      csr_write(REG_KEY_W0, 64'h0001020304050607);
      csr_write(REG_KEY_W1, 64'h08090a0b0c0d0e0f);
      pending_requests.push_back(make_request(OP_ENCRYPT, 64'h0011223344556677,
                                              64'h8899aabbccddeeff));
      pending_requests.push_back(make_request(OP_DECRYPT, 64'h69c4e0d86a7b0430,
                                              64'hd8cdb78070b4c55a));
      drain();

      // A write beyond the register list leaves the schedule in place.
      csr_write(REG_BEYOND, '1);
      pending_requests.push_back(make_request(OP_ENCRYPT, 64'h0011223344556677,
                                              64'h8899aabbccddeeff));
      drain();

      // Standard 192-bit and 256-bit keys, then the unused size code.
      csr_write(REG_KEY_W2, 64'h1011121314151617);
      csr_write(REG_KEY_SIZE, {62'd0, KEY_SIZE_192});
      pending_requests.push_back(make_request(OP_ENCRYPT, 64'h0011223344556677,
                                              64'h8899aabbccddeeff));
      pending_requests.push_back(make_request(OP_DECRYPT, 64'hdda97ca4864cdfe0,
                                              64'h6eaf70a0ec0d7191));
      drain();
      csr_write(REG_KEY_W3, 64'h18191a1b1c1d1e1f);
      csr_write(REG_KEY_SIZE, {62'd0, KEY_SIZE_256});
      pending_requests.push_back(make_request(OP_ENCRYPT, 64'h0011223344556677,
                                              64'h8899aabbccddeeff));
      pending_requests.push_back(make_request(OP_DECRYPT, 64'h8ea2b7ca516745bf,
                                              64'heafc49904b496089));
      drain();
      csr_write(REG_KEY_SIZE, {62'd0, KEY_SIZE_UNUSED});
      pending_requests.push_back(make_request(OP_ENCRYPT, '1, '0));
      pending_requests.push_back(make_request(OP_DECRYPT, '0, '1));
      drain();

      // Random phases: every size code, keys at both extremes and random.
      for (int ph = 0; ph < PHASES; ph++) begin
         ks = ph[1:0];
         if (ph == PHASES - 1) calm = 1'b1;
         csr_write(REG_KEY_SIZE, {62'd0, ks});
         for (int w = 0; w < 4; w++)
            csr_write(REG_KEY_W0 + w[2:0], ph == 4 ? '1 : (ph == 5 ? '0 : rand64()));
         for (int n = 0; n < 84; n++)
            pending_requests.push_back(make_request(1'($urandom_range(1)), rand64(),
                                                    rand64()));
         drain();
      end

      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
